// ===== hw/rtl/event_rate_meter_peak_normalized_assert.svh =====
// ----------------------------------------------------------------------------
// event rate meter assertion macros
// concurrent checks on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef EVENT_RATE_METER_PEAK_NORMALIZED_ASSERT_SVH
`define EVENT_RATE_METER_PEAK_NORMALIZED_ASSERT_SVH

// same-cycle implication
`define ERPN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ERPN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/erpn_pkg.sv =====
// ----------------------------------------------------------------------------
// erpn_pkg
// widths, reset values, register indexes and state type of the event rate meter
// ----------------------------------------------------------------------------
`default_nettype none

package erpn_pkg;

  localparam int WINDOW_LEN = 20;

  localparam int COUNT_W = 8;
  localparam int SCALE_W = 10;
  localparam int RATE_W  = 18;
  localparam int LEVEL_W = 7;

  localparam int SUM_W  = $clog2(WINDOW_LEN * (2 ** RATE_W - 1) + 1);
  localparam int SLOT_W = $clog2(WINDOW_LEN);
  localparam int REM_W  = $clog2(WINDOW_LEN);
  localparam int CNT_W  = $clog2(SUM_W);
  localparam int PROD_W = RATE_W + LEVEL_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RATE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE_SCALE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_FLOOR = CFG_IDX_W'(1);

  localparam logic [SCALE_W-1:0] RATE_SCALE_RESET = SCALE_W'(300);
  localparam logic [RATE_W-1:0]  PEAK_FLOOR_RESET = RATE_W'(100);
  localparam logic [LEVEL_W-1:0] LEVEL_FULL       = LEVEL_W'(100);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_AVG,
    S_PEAK,
    S_LVL,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/event_rate_meter_peak_normalized.sv =====
// ----------------------------------------------------------------------------
// event_rate_meter_peak_normalized: windowed event rate with peak level
// an accepted item passes the 8-step multiply, the window sum step, the
// 23-step divide, the peak step and the 7-step level divide to out_valid;
// no new item is taken until the result loads; a stalled result holds the last step
// sync reset: scale 300, peak 100, window and sum zero, no item pending
// ----------------------------------------------------------------------------
`default_nettype none

`include "event_rate_meter_peak_normalized_assert.svh"

module event_rate_meter_peak_normalized (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [erpn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [erpn_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [erpn_pkg::COUNT_W-1:0]      event_count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [erpn_pkg::LEVEL_W-1:0]      level_percent,
  output logic [erpn_pkg::RATE_W-1:0]       average_rate,
  output logic [erpn_pkg::RATE_W-1:0]       peak_rate
);

  import erpn_pkg::*;

  localparam logic [CNT_W-1:0] MUL_END = CNT_W'(COUNT_W - 1);
  localparam logic [CNT_W-1:0] AVG_END = CNT_W'(SUM_W - 1);
  localparam logic [CNT_W-1:0] LVL_END = CNT_W'(LEVEL_W - 1);

  state_t              state;
  state_t              state_next;
  logic [CNT_W-1:0]    cnt;

  logic [SCALE_W-1:0]  rate_scale;
  logic [RATE_W-1:0]   peak_value;
  logic [RATE_W-1:0]   rate_window [WINDOW_LEN];
  logic [SLOT_W-1:0]   write_slot;
  logic [SUM_W-1:0]    window_sum;

  logic [COUNT_W-1:0]  mshift;
  logic [RATE_W-1:0]   acc;
  logic [REM_W-1:0]    drem;
  logic [SUM_W-1:0]    quo;
  logic [RATE_W-1:0]   avg_q;
  logic [PROD_W-1:0]   lrem;
  logic [PROD_W-1:0]   ldiv;
  logic [LEVEL_W-1:0]  lq;

  logic                out_load;
  logic [RATE_W-1:0]   acc_next;
  logic [SUM_W-1:0]    sum_next;
  logic [REM_W:0]      trial;
  logic                trial_ge;
  logic [RATE_W-1:0]   avg_new;
  logic [RATE_W-1:0]   peak_new;
  logic [PROD_W-1:0]   prod;
  logic                lge;
  logic [SLOT_W-1:0]   slot_next;

  // datapath terms
  always_comb begin
    acc_next  = {acc[RATE_W-2:0], 1'b0} +
                (mshift[COUNT_W-1] ? RATE_W'(rate_scale) : RATE_W'(0));
    sum_next  = window_sum - SUM_W'(rate_window[write_slot]) + SUM_W'(acc);
    slot_next = (write_slot == SLOT_W'(WINDOW_LEN - 1)) ? SLOT_W'(0)
                                                         : write_slot + SLOT_W'(1);
    trial     = {drem, quo[SUM_W-1]};
    trial_ge  = trial >= (REM_W + 1)'(WINDOW_LEN);
    avg_new   = quo[RATE_W-1:0];
    peak_new  = (avg_new > peak_value) ? avg_new : peak_value;
    prod      = PROD_W'(avg_new) * PROD_W'(LEVEL_FULL);
    lge       = lrem >= ldiv;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_MUL;
      S_MUL:  if (cnt == MUL_END) state_next = S_SUM;
      S_SUM:  state_next = S_AVG;
      S_AVG:  if (cnt == AVG_END) state_next = S_PEAK;
      S_PEAK: state_next = S_LVL;
      S_LVL:  if (cnt == LVL_END) state_next = S_DONE;
      S_DONE: if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_stall = (state != S_IDLE);
    out_load = (state == S_DONE) && (!out_valid || !out_stall);
  end

  // control and stored state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      rate_scale <= RATE_SCALE_RESET;
      peak_value <= PEAK_FLOOR_RESET;
      write_slot <= SLOT_W'(0);
      window_sum <= SUM_W'(0);
      for (int i = 0; i < WINDOW_LEN; i++) begin
        rate_window[i] <= RATE_W'(0);
      end
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_write && cfg_index == CFG_RATE_SCALE) begin
        rate_scale <= cfg_data[SCALE_W-1:0];
      end
      if (cfg_write && cfg_index == CFG_PEAK_FLOOR) begin
        peak_value <= cfg_data[RATE_W-1:0];
      end else if (state == S_PEAK) begin
        peak_value <= peak_new;
      end
      if (state == S_SUM) begin
        window_sum              <= sum_next;
        rate_window[write_slot] <= acc;
        write_slot              <= slot_next;
      end
    end
  end

  // serial datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        mshift <= event_count;
        acc    <= RATE_W'(0);
        cnt    <= CNT_W'(0);
      end
      S_MUL: begin
        acc    <= acc_next;
        mshift <= {mshift[COUNT_W-2:0], 1'b0};
        cnt    <= (cnt == MUL_END) ? CNT_W'(0) : cnt + CNT_W'(1);
      end
      S_SUM: begin
        quo  <= sum_next;
        drem <= REM_W'(0);
        cnt  <= CNT_W'(0);
      end
      S_AVG: begin
        drem <= trial_ge ? REM_W'(trial - (REM_W + 1)'(WINDOW_LEN)) : trial[REM_W-1:0];
        quo  <= {quo[SUM_W-2:0], trial_ge};
        cnt  <= (cnt == AVG_END) ? CNT_W'(0) : cnt + CNT_W'(1);
      end
      S_PEAK: begin
        avg_q <= avg_new;
        lrem  <= prod;
        ldiv  <= PROD_W'(peak_new) << (LEVEL_W - 1);
        lq    <= LEVEL_W'(0);
        cnt   <= CNT_W'(0);
      end
      S_LVL: begin
        lrem <= lge ? lrem - ldiv : lrem;
        lq   <= {lq[LEVEL_W-2:0], lge};
        ldiv <= ldiv >> 1;
        cnt  <= (cnt == LVL_END) ? CNT_W'(0) : cnt + CNT_W'(1);
      end
      S_DONE: begin
        cnt <= CNT_W'(0);
      end
      default: begin
        cnt <= CNT_W'(0);
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      level_percent <= (peak_value == RATE_W'(0)) ? LEVEL_W'(0) : lq;
      average_rate  <= avg_q;
      peak_rate     <= peak_value;
    end
  end

  `ERPN_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state == S_MUL, "no multiply")
  `ERPN_ASSERT_NOW(a_level_bound, out_valid, level_percent <= LEVEL_FULL, "level above full")
  `ERPN_ASSERT_NOW(a_peak_bound, out_valid, peak_rate >= average_rate, "peak below average")
  `ERPN_ASSERT_NOW(a_slot_range, 1'b1, write_slot < SLOT_W'(WINDOW_LEN), "slot past window end")

endmodule

`default_nettype wire
